/* rtl/core/sqr_pkg.sv */
`timescale 1ns / 1ps

package sqr_pkg;

  // default number format, signed Q16.16
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COEF_WIDTH_DEF = 32;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_ROOT  = 2'd1,
    STATUS_DIV_ZERO = 2'd2
  } status_t;

  // per-item flags that ride along the root and divide chains
  typedef struct packed {
    status_t status;
    logic    dzero;
    logic    neg0;
    logic    neg1;
  } sqr_flags_t;

endpackage

/* rtl/core/sqr_in_if.sv */
`timescale 1ns / 1ps

interface sqr_in_if import sqr_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

/* rtl/core/sqr_out_if.sv */
`timescale 1ns / 1ps

interface sqr_out_if import sqr_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  status_t                      status;
  logic signed [COEF_WIDTH-1:0] root_low;
  logic signed [COEF_WIDTH-1:0] root_high;
  logic                         saturated;

  modport source (output valid, status, root_low, root_high, saturated, input ready);
  modport sink   (input valid, status, root_low, root_high, saturated, output ready);
endinterface

/* rtl/core/sqr_mul_cell.sv */
`timescale 1ns / 1ps

module sqr_mul_cell #(
  parameter int W     = 32,
  parameter int CTX_W = 99
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [2*W-1:0]   in_xa,
  input  logic [W-1:0]     in_ya,
  input  logic [2*W-1:0]   in_acca,
  input  logic [2*W-1:0]   in_xb,
  input  logic [W-1:0]     in_yb,
  input  logic [2*W-1:0]   in_accb,
  input  logic [CTX_W-1:0] in_ctx,
  output logic             out_vld,
  output logic [2*W-1:0]   out_xa,
  output logic [W-1:0]     out_ya,
  output logic [2*W-1:0]   out_acca,
  output logic [2*W-1:0]   out_xb,
  output logic [W-1:0]     out_yb,
  output logic [2*W-1:0]   out_accb,
  output logic [CTX_W-1:0] out_ctx
);
  logic             vld_r;
  logic [2*W-1:0]   xa_r, acca_r, xb_r, accb_r;
  logic [W-1:0]     ya_r, yb_r;
  logic [CTX_W-1:0] ctx_r;
  logic [2*W-1:0]   acca_nxt, accb_nxt;

  // one partial product per product, multiplier bit taken from the bottom
  assign acca_nxt = in_acca + (in_ya[0] ? in_xa : '0);
  assign accb_nxt = in_accb + (in_yb[0] ? in_xb : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r   <= {in_xa[2*W-2:0], 1'b0};
      xb_r   <= {in_xb[2*W-2:0], 1'b0};
      ya_r   <= {1'b0, in_ya[W-1:1]};
      yb_r   <= {1'b0, in_yb[W-1:1]};
      acca_r <= acca_nxt;
      accb_r <= accb_nxt;
      ctx_r  <= in_ctx;
    end
  end

  assign out_vld  = vld_r;
  assign out_xa   = xa_r;
  assign out_ya   = ya_r;
  assign out_acca = acca_r;
  assign out_xb   = xb_r;
  assign out_yb   = yb_r;
  assign out_accb = accb_r;
  assign out_ctx  = ctx_r;
endmodule

/* rtl/core/sqr_root_cell.sv */
`timescale 1ns / 1ps

module sqr_root_cell #(
  parameter int RW    = 33,
  parameter int CTX_W = 101
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [2*RW-1:0]  in_rad,
  input  logic [RW+2:0]    in_rem,
  input  logic [RW-1:0]    in_root,
  input  logic [CTX_W-1:0] in_ctx,
  output logic             out_vld,
  output logic [2*RW-1:0]  out_rad,
  output logic [RW+2:0]    out_rem,
  output logic [RW-1:0]    out_root,
  output logic [CTX_W-1:0] out_ctx
);
  logic             vld_r;
  logic [2*RW-1:0]  rad_r;
  logic [RW+2:0]    rem_r, rem_nxt, rem_sh, trial;
  logic [RW-1:0]    root_r, root_nxt;
  logic [CTX_W-1:0] ctx_r;
  logic             ge;

  // restoring square root, one result bit per cell
  assign rem_sh   = {in_rem[RW:0], in_rad[2*RW-1:2*RW-2]};
  assign trial    = {1'b0, in_root, 2'b01};
  assign ge       = rem_sh >= trial;
  assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {in_root[RW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {in_rad[2*RW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      ctx_r  <= in_ctx;
    end
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_ctx  = ctx_r;
endmodule

/* rtl/core/sqr_div_cell.sv */
`timescale 1ns / 1ps

module sqr_div_cell #(
  parameter int NW    = 50,
  parameter int DNW   = 34,
  parameter int CTX_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NW-1:0]    in_num0,
  input  logic [NW-1:0]    in_num1,
  input  logic [NW-1:0]    in_q0,
  input  logic [NW-1:0]    in_q1,
  input  logic [DNW-1:0]   in_rem0,
  input  logic [DNW-1:0]   in_rem1,
  input  logic [DNW-1:0]   in_den0,
  input  logic [DNW-1:0]   in_den1,
  input  logic [CTX_W-1:0] in_ctx,
  output logic             out_vld,
  output logic [NW-1:0]    out_num0,
  output logic [NW-1:0]    out_num1,
  output logic [NW-1:0]    out_q0,
  output logic [NW-1:0]    out_q1,
  output logic [DNW-1:0]   out_rem0,
  output logic [DNW-1:0]   out_rem1,
  output logic [DNW-1:0]   out_den0,
  output logic [DNW-1:0]   out_den1,
  output logic [CTX_W-1:0] out_ctx
);
  logic             vld_r;
  logic [NW-1:0]    num0_r, num1_r, q0_r, q1_r;
  logic [DNW-1:0]   rem0_r, rem1_r, den0_r, den1_r;
  logic [CTX_W-1:0] ctx_r;
  logic [DNW:0]     rs0, rs1, df0, df1;
  logic             ge0, ge1;

  // restoring division, one quotient bit per cell for both quotients
  assign rs0 = {in_rem0, in_num0[NW-1]};
  assign rs1 = {in_rem1, in_num1[NW-1]};
  assign ge0 = rs0 >= {1'b0, in_den0};
  assign ge1 = rs1 >= {1'b0, in_den1};
  assign df0 = rs0 - {1'b0, in_den0};
  assign df1 = rs1 - {1'b0, in_den1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= {in_num0[NW-2:0], 1'b0};
      num1_r <= {in_num1[NW-2:0], 1'b0};
      q0_r   <= {in_q0[NW-2:0], ge0};
      q1_r   <= {in_q1[NW-2:0], ge1};
      rem0_r <= ge0 ? df0[DNW-1:0] : rs0[DNW-1:0];
      rem1_r <= ge1 ? df1[DNW-1:0] : rs1[DNW-1:0];
      den0_r <= in_den0;
      den1_r <= in_den1;
      ctx_r  <= in_ctx;
    end
  end

  assign out_vld  = vld_r;
  assign out_num0 = num0_r;
  assign out_num1 = num1_r;
  assign out_q0   = q0_r;
  assign out_q1   = q1_r;
  assign out_rem0 = rem0_r;
  assign out_rem1 = rem1_r;
  assign out_den0 = den0_r;
  assign out_den1 = den1_r;
  assign out_ctx  = ctx_r;
endmodule

/* rtl/core/stable_quadratic_roots_unit.sv */
// Real roots of a*x*x + b*x + c = 0 for signed fixed-point coefficients
// (COEF_WIDTH bits, FRAC_BITS fraction bits, Q16.16 by default), solved the
// numerically stable way: q = -(b + sign(b)*sqrt(b*b-4ac))/2, roots q/a and
// c/q, smaller root first, each in the coefficient format (Q16.16 by
// default), truncated toward zero and clamped to the coefficient range
// with the saturated flag set. A zero a gives status 2, a negative
// discriminant status 1, both with zero roots. The unit takes one
// coefficient set per clock unless held; it is built from three rows of
// one-bit cells: COEF_WIDTH multiply cells, COEF_WIDTH+1 square root
// cells and COEF_WIDTH+FRAC_BITS+2 divide cells. A two-entry output
// buffer lets the pipeline keep moving while one result waits to be
// taken; the whole pipeline holds only when that buffer is full.
`timescale 1ns / 1ps

module stable_quadratic_roots_unit import sqr_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sqr_in_if.sink      in_chan,
  sqr_out_if.source   out_chan
);
  localparam int W      = COEF_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int PW     = 2 * W;
  localparam int DW     = 2 * W + 1;
  localparam int RW     = W + 1;
  localparam int SW     = 2 * RW;
  localparam int REMW   = RW + 3;
  localparam int TW     = W + 2;
  localparam int NW     = W + 2 + F;
  localparam int FLG_W  = $bits(sqr_flags_t);
  localparam int MCTX_W = 3 + 3 * W;
  localparam int SCTX_W = FLG_W + 3 * W;
  localparam int RES_W  = 2 + 2 * W + 1;
  localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);
  localparam logic [NW-1:0] LIM_POS = LIM_NEG - NW'(1);

  logic en;

  // input register, coefficients split into sign and magnitude
  logic         s0_vld_r;
  logic [W-1:0] s0_ma_r, s0_mb_r, s0_mc_r;
  logic         s0_sa_r, s0_sb_r, s0_sc_r;

  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sa_r <= in_chan.coef_a[W-1];
      s0_sb_r <= in_chan.coef_b[W-1];
      s0_sc_r <= in_chan.coef_c[W-1];
      s0_ma_r <= in_chan.coef_a[W-1] ? (~in_chan.coef_a + 1'b1) : in_chan.coef_a;
      s0_mb_r <= in_chan.coef_b[W-1] ? (~in_chan.coef_b + 1'b1) : in_chan.coef_b;
      s0_mc_r <= in_chan.coef_c[W-1] ? (~in_chan.coef_c + 1'b1) : in_chan.coef_c;
    end
  end

  // multiply row: b*b and a*c, one multiplier bit per cell
  logic              m_vld  [0:W];
  logic [PW-1:0]     m_xa   [0:W];
  logic [W-1:0]      m_ya   [0:W];
  logic [PW-1:0]     m_acca [0:W];
  logic [PW-1:0]     m_xb   [0:W];
  logic [W-1:0]      m_yb   [0:W];
  logic [PW-1:0]     m_accb [0:W];
  logic [MCTX_W-1:0] m_ctx  [0:W];

  assign m_vld[0]  = s0_vld_r;
  assign m_xa[0]   = {{W{1'b0}}, s0_mb_r};
  assign m_ya[0]   = s0_mb_r;
  assign m_acca[0] = '0;
  assign m_xb[0]   = {{W{1'b0}}, s0_ma_r};
  assign m_yb[0]   = s0_mc_r;
  assign m_accb[0] = '0;
  assign m_ctx[0]  = {s0_sa_r, s0_sb_r, s0_sc_r, s0_ma_r, s0_mb_r, s0_mc_r};

  for (genvar i = 0; i < W; i++) begin : g_mul
    sqr_mul_cell #(.W(W), .CTX_W(MCTX_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (m_vld[i]),
      .in_xa    (m_xa[i]),
      .in_ya    (m_ya[i]),
      .in_acca  (m_acca[i]),
      .in_xb    (m_xb[i]),
      .in_yb    (m_yb[i]),
      .in_accb  (m_accb[i]),
      .in_ctx   (m_ctx[i]),
      .out_vld  (m_vld[i+1]),
      .out_xa   (m_xa[i+1]),
      .out_ya   (m_ya[i+1]),
      .out_acca (m_acca[i+1]),
      .out_xb   (m_xb[i+1]),
      .out_yb   (m_yb[i+1]),
      .out_accb (m_accb[i+1]),
      .out_ctx  (m_ctx[i+1])
    );
  end

  // discriminant, status and root signs
  logic         mo_sa, mo_sb, mo_sc;
  logic [W-1:0] mo_ma, mo_mb, mo_mc;
  logic [PW+1:0] ac4, b2e, dsum;
  logic         same_sign, b_pos;
  sqr_flags_t   dc_flags;

  assign {mo_sa, mo_sb, mo_sc, mo_ma, mo_mb, mo_mc} = m_ctx[W];
  assign ac4       = {m_accb[W], 2'b00};
  assign b2e       = {2'b00, m_acca[W]};
  assign same_sign = (mo_ma != '0) && (mo_mc != '0) && (mo_sa == mo_sc);
  assign dsum      = same_sign ? (b2e - ac4) : (b2e + ac4);
  assign b_pos     = !mo_sb && (mo_mb != '0);

  always_comb begin
    priority if (same_sign && (b2e < ac4)) begin
      dc_flags.status = STATUS_NO_ROOT;
    end else if (mo_ma == '0) begin
      dc_flags.status = STATUS_DIV_ZERO;
    end else begin
      dc_flags.status = STATUS_OK;
    end
    dc_flags.dzero = (dsum[DW-1:0] == '0);
    dc_flags.neg0  = b_pos != mo_sa;
    dc_flags.neg1  = mo_sc != b_pos;
  end

  logic          dc_vld_r;
  logic [DW-1:0] dc_d_r;
  sqr_flags_t    dc_flags_r;
  logic [W-1:0]  dc_ma_r, dc_mb_r, dc_mc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_vld_r <= 1'b0;
    end else if (en) begin
      dc_vld_r <= m_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc_d_r     <= dsum[DW-1:0];
      dc_flags_r <= dc_flags;
      dc_ma_r    <= mo_ma;
      dc_mb_r    <= mo_mb;
      dc_mc_r    <= mo_mc;
    end
  end

  // square root row, one root bit per cell
  logic              s_vld  [0:RW];
  logic [SW-1:0]     s_rad  [0:RW];
  logic [REMW-1:0]   s_rem  [0:RW];
  logic [RW-1:0]     s_root [0:RW];
  logic [SCTX_W-1:0] s_ctx  [0:RW];

  assign s_vld[0]  = dc_vld_r;
  assign s_rad[0]  = {1'b0, dc_d_r};
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_ctx[0]  = {dc_flags_r, dc_ma_r, dc_mb_r, dc_mc_r};

  for (genvar i = 0; i < RW; i++) begin : g_root
    sqr_root_cell #(.RW(RW), .CTX_W(SCTX_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (s_vld[i]),
      .in_rad   (s_rad[i]),
      .in_rem   (s_rem[i]),
      .in_root  (s_root[i]),
      .in_ctx   (s_ctx[i]),
      .out_vld  (s_vld[i+1]),
      .out_rad  (s_rad[i+1]),
      .out_rem  (s_rem[i+1]),
      .out_root (s_root[i+1]),
      .out_ctx  (s_ctx[i+1])
    );
  end

  // 2|q| = |b| + sqrt(D), dividends and divisors for both roots
  sqr_flags_t   so_flags;
  logic [W-1:0] so_ma, so_mb, so_mc;
  logic [TW-1:0] tm;

  assign {so_flags, so_ma, so_mb, so_mc} = s_ctx[RW];
  assign tm = {2'b00, so_mb} + {1'b0, s_root[RW]};

  logic          t_vld_r;
  sqr_flags_t    t_flags_r;
  logic [NW-1:0] t_num0_r, t_num1_r;
  logic [TW-1:0] t_den0_r, t_den1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (en) begin
      t_vld_r <= s_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_flags_r <= so_flags;
      t_num0_r  <= {tm, {F{1'b0}}};
      t_num1_r  <= {1'b0, so_mc, {(F + 1){1'b0}}};
      t_den0_r  <= {1'b0, so_ma, 1'b0};
      t_den1_r  <= tm;
    end
  end

  // divide row, one quotient bit per cell
  logic             v_vld  [0:NW];
  logic [NW-1:0]    v_num0 [0:NW];
  logic [NW-1:0]    v_num1 [0:NW];
  logic [NW-1:0]    v_q0   [0:NW];
  logic [NW-1:0]    v_q1   [0:NW];
  logic [TW-1:0]    v_rem0 [0:NW];
  logic [TW-1:0]    v_rem1 [0:NW];
  logic [TW-1:0]    v_den0 [0:NW];
  logic [TW-1:0]    v_den1 [0:NW];
  logic [FLG_W-1:0] v_ctx  [0:NW];

  assign v_vld[0]  = t_vld_r;
  assign v_num0[0] = t_num0_r;
  assign v_num1[0] = t_num1_r;
  assign v_q0[0]   = '0;
  assign v_q1[0]   = '0;
  assign v_rem0[0] = '0;
  assign v_rem1[0] = '0;
  assign v_den0[0] = t_den0_r;
  assign v_den1[0] = t_den1_r;
  assign v_ctx[0]  = t_flags_r;

  for (genvar i = 0; i < NW; i++) begin : g_div
    sqr_div_cell #(.NW(NW), .DNW(TW), .CTX_W(FLG_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (v_vld[i]),
      .in_num0  (v_num0[i]),
      .in_num1  (v_num1[i]),
      .in_q0    (v_q0[i]),
      .in_q1    (v_q1[i]),
      .in_rem0  (v_rem0[i]),
      .in_rem1  (v_rem1[i]),
      .in_den0  (v_den0[i]),
      .in_den1  (v_den1[i]),
      .in_ctx   (v_ctx[i]),
      .out_vld  (v_vld[i+1]),
      .out_num0 (v_num0[i+1]),
      .out_num1 (v_num1[i+1]),
      .out_q0   (v_q0[i+1]),
      .out_q1   (v_q1[i+1]),
      .out_rem0 (v_rem0[i+1]),
      .out_rem1 (v_rem1[i+1]),
      .out_den0 (v_den0[i+1]),
      .out_den1 (v_den1[i+1]),
      .out_ctx  (v_ctx[i+1])
    );
  end

  // clamp, apply sign, pick the double root case
  sqr_flags_t        vo_flags;
  logic [NW-1:0]     lim0, lim1;
  logic              over0, over1, res_ok;
  logic [W-1:0]      mag0, mag1;
  logic signed [W-1:0] x0v, x1v;

  assign vo_flags = sqr_flags_t'(v_ctx[NW]);
  assign lim0     = vo_flags.neg0 ? LIM_NEG : LIM_POS;
  assign lim1     = vo_flags.neg1 ? LIM_NEG : LIM_POS;
  assign over0    = v_q0[NW] > lim0;
  assign over1    = v_q1[NW] > lim1;
  assign mag0     = over0 ? lim0[W-1:0] : v_q0[NW][W-1:0];
  assign mag1     = over1 ? lim1[W-1:0] : v_q1[NW][W-1:0];
  assign x0v      = vo_flags.neg0 ? (~mag0 + 1'b1) : mag0;
  assign x1v      = vo_flags.neg1 ? (~mag1 + 1'b1) : mag1;
  assign res_ok   = vo_flags.status == STATUS_OK;

  logic                f_vld_r;
  status_t             f_status_r;
  logic signed [W-1:0] f_x0_r, f_x1_r;
  logic                f_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= v_vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_status_r <= vo_flags.status;
      f_x0_r     <= res_ok ? x0v : '0;
      f_x1_r     <= res_ok ? (vo_flags.dzero ? x0v : x1v) : '0;
      f_sat_r    <= res_ok && (over0 || (!vo_flags.dzero && over1));
    end
  end

  // order roots and hand over to the two-entry output buffer
  logic [RES_W-1:0] res_new, head_r, slot_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop, swap;

  assign swap    = f_x0_r > f_x1_r;
  assign res_new = {f_status_r, (swap ? f_x1_r : f_x0_r), (swap ? f_x0_r : f_x1_r), f_sat_r};
  assign en      = !f_vld_r || (cnt_r != 2'd2);
  assign push    = f_vld_r && en;
  assign pop     = out_chan.valid && out_chan.ready;
  assign cnt_nxt = 2'(cnt_r + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // a push alongside a transfer out only happens with one entry held
  always_ff @(posedge clk) begin
    if (pop) begin
      head_r <= push ? res_new : slot_r;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_r <= res_new;
      end else begin
        slot_r <= res_new;
      end
    end
  end

  assign out_chan.valid     = cnt_r != 2'd0;
  assign out_chan.status    = status_t'(head_r[RES_W-1:RES_W-2]);
  assign out_chan.root_low  = head_r[2*W:W+1];
  assign out_chan.root_high = head_r[W:1];
  assign out_chan.saturated = head_r[0];
endmodule
